@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define SPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SPQ_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/spq_pkg.sv @@
// Types and constants of the sorted priority queue.
package spq_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic               op;
    logic signed [31:0] data_in;
    logic [7:0]         priority_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data_out;
    logic [7:0]         priority_out;
    logic [3:0]         fill_count;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic [7:0]         prio;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_cmd_t;

endpackage

@@ rtl/spq_cell.sv @@
// One slot of the sorted queue: keeps, loads the new entry or takes a neighbor's entry.
module spq_cell
  import spq_pkg::*;
(
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  logic      occ,
  input  logic      left_ge,
  input  entry_t    left_entry,
  input  entry_t    right_entry,
  input  entry_t    new_entry,
  output logic      ge,
  output entry_t    entry
);

  entry_t entry_r;
  entry_t entry_nxt;

  // An occupied slot whose priority is at least the new one stays ahead of it.
  assign ge    = occ && (entry_r.prio >= new_entry.prio);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    priority if (cmd.ins) begin
      priority if (ge) begin
        entry_nxt = entry_r;
      end else if (left_ge) begin
        entry_nxt = new_entry;
      end else begin
        entry_nxt = left_entry;
      end
    end else if (cmd.rem) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

@@ rtl/spq_out_buf.sv @@
// Output register with a skid stage, so a stalled receiver does not lose an item.
module spq_out_buf
  import spq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_item,
  output logic      busy,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic      main_v_r, main_v_nxt;
  logic      skid_v_r, skid_v_nxt;
  out_item_t main_r, main_nxt;
  out_item_t skid_r, skid_nxt;
  logic      pop;

  assign pop       = main_v_r && !out_stall;
  assign busy      = skid_v_r;
  assign out_valid = main_v_r;
  assign out_item  = main_r;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (pop) begin
      main_v_nxt = 1'b0;
    end
    // A new item must arrive only while the skid stage is empty; this block does not enforce it.
    if (pop && skid_v_r) begin
      main_v_nxt = 1'b1;
      main_nxt   = skid_r;
      skid_v_nxt = 1'b0;
    end else if (push) begin
      if (!main_v_r || pop) begin
        main_v_nxt = 1'b1;
        main_nxt   = push_item;
      end else begin
        skid_v_nxt = 1'b1;
        skid_nxt   = push_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

@@ rtl/sorted_priority_queue.sv @@
// Bounded priority queue kept in a row of slots sorted by priority, highest first.
// Input channel: in_valid/in_stall with in_item carrying op, data_in and priority_in.
// An insert places the entry behind all stored entries of equal or higher priority;
// a remove returns the front entry. Every item gives exactly one result on the
// out_valid/out_stall channel with a status, the removed entry (zero otherwise) and
// the fill count after the item. A full insert or an empty remove is refused and
// leaves the queue as it was.
// Throughput: one item per cycle while in_stall is low; every slot compares and
// shifts in parallel, so the whole row updates in the cycle the item is accepted.
// A skid stage behind the output register holds one extra result; in_stall rises
// only when both are taken and the receiver stalls, and no result is dropped.
// Reset (rst_n low at a rising edge) empties the queue and the output stages.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W+3:0] count_ext;
  logic             accept;
  logic             full;
  logic             empty;
  logic             ins_ok;
  logic             rem_ok;
  cell_cmd_t        cmd;
  entry_t           new_entry;
  entry_t           cell_entry [DEPTH];
  logic             cell_ge    [DEPTH];
  out_item_t        result;
  logic             buf_busy;

  assign accept = in_valid && !in_stall;
  assign full   = (count_r == CNT_W'(DEPTH));
  assign empty  = (count_r == '0);
  assign ins_ok = accept && (in_item.op == OP_INSERT) && !full;
  assign rem_ok = accept && (in_item.op == OP_REMOVE) && !empty;

  assign cmd.ins        = ins_ok;
  assign cmd.rem        = rem_ok;
  assign new_entry.data = in_item.data_in;
  assign new_entry.prio = in_item.priority_in;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      entry_t left_entry;
      entry_t right_entry;
      logic   left_ge;
      if (gi == 0) begin : g_first
        // The front slot has nothing ahead of it.
        assign left_ge    = 1'b1;
        assign left_entry = new_entry;
      end else begin : g_inner
        assign left_ge    = cell_ge[gi-1];
        assign left_entry = cell_entry[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign right_entry = cell_entry[gi];
      end else begin : g_mid
        assign right_entry = cell_entry[gi+1];
      end
      spq_cell u_cell (
        .clk         (clk),
        .cmd         (cmd),
        .occ         (CNT_W'(gi) < count_r),
        .left_ge     (left_ge),
        .left_entry  (left_entry),
        .right_entry (right_entry),
        .new_entry   (new_entry),
        .ge          (cell_ge[gi]),
        .entry       (cell_entry[gi])
      );
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (ins_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (rem_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign count_ext = {4'b0000, count_nxt};

  always_comb begin
    result.status       = ST_OK;
    result.data_out     = '0;
    result.priority_out = '0;
    result.fill_count   = count_ext[3:0];
    if (in_item.op == OP_INSERT && full) begin
      result.status = ST_FULL;
    end else if (in_item.op == OP_REMOVE && empty) begin
      result.status = ST_EMPTY;
    end
    if (rem_ok) begin
      result.data_out     = cell_entry[0].data;
      result.priority_out = cell_entry[0].prio;
    end
  end

  spq_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_item (result),
    .busy      (buf_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  assign in_stall = buf_busy;

endmodule

@@ rtl/spq_checker.sv @@
// Port-level checks of the sorted priority queue and their bind to the top level.
`include "assert_macros.svh"

module spq_checker
  import spq_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  `SPQ_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_item), "stalled result changed")
  `SPQ_ASSERT(a_empty_cnt, out_valid && out_item.status == ST_EMPTY |-> out_item.fill_count == 4'd0 && out_item.data_out == 32'sd0, "empty refusal with entries or data")
  `SPQ_ASSERT(a_full_cnt, out_valid && out_item.status == ST_FULL |-> out_item.fill_count == 4'(DEPTH) && out_item.priority_out == 8'd0, "full refusal with wrong count")
  `SPQ_ASSERT(a_accept_result, in_valid && !in_stall |=> out_valid, "accepted item gave no result")
  `SPQ_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid && !in_stall, "result or stall after reset")

endmodule

bind sorted_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (.*);

@@ verif/testbench.sv @@
// Self-checking testbench of the sorted priority queue: directed table, random items, stalls.
`timescale 1ns / 1ps

module testbench;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH   = 8;
  localparam int DIRECTED_ROWS = 21;
  localparam int RANDOM_ITEMS  = 200;
  localparam int PRESSURE_ITEMS = 60;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 300000;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t result;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // Predicted contents of the queue, front first.
  logic signed [31:0] held_data [QUEUE_DEPTH];
  logic [7:0]         held_prio [QUEUE_DEPTH];
  int                 held_count = 0;

  out_item_t expected_results [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_request   = 1'b0;

  int cycle_count     = 0;
  int mismatch_count  = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int full_refusals   = 0;
  int empty_refusals  = 0;
  int peak_fill       = 0;
  int input_stalls    = 0;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{OP_REMOVE, 32'h1234_5678, 8'h3C}, 1'b1, '{ST_EMPTY, 32'h0, 8'd0, 4'd0}},
    '{'{OP_INSERT, 32'h7FFF_FFFF, 8'd0},   1'b1, '{ST_OK, 32'h0, 8'd0, 4'd1}},
    '{'{OP_INSERT, 32'h8000_0000, 8'd255}, 1'b1, '{ST_OK, 32'h0, 8'd0, 4'd2}},
    '{'{OP_INSERT, 32'hFFFF_FFFF, 8'd128}, 1'b1, '{ST_OK, 32'h0, 8'd0, 4'd3}},
    '{'{OP_INSERT, 32'h0000_0000, 8'd128}, 1'b1, '{ST_OK, 32'h0, 8'd0, 4'd4}},
    '{'{OP_INSERT, 32'h0000_0001, 8'd255}, 1'b1, '{ST_OK, 32'h0, 8'd0, 4'd5}},
    '{'{OP_INSERT, 32'h5555_5555, 8'hAA},  1'b1, '{ST_OK, 32'h0, 8'd0, 4'd6}},
    '{'{OP_INSERT, 32'hAAAA_AAAA, 8'h55},  1'b1, '{ST_OK, 32'h0, 8'd0, 4'd7}},
    '{'{OP_INSERT, 32'h0000_0002, 8'd0},   1'b1, '{ST_OK, 32'h0, 8'd0, 4'd8}},
    '{'{OP_INSERT, 32'h0000_0003, 8'd77},  1'b1, '{ST_FULL, 32'h0, 8'd0, 4'd8}},
    '{'{OP_REMOVE, 32'hDEAD_BEEF, 8'hFF},  1'b0, '0},
    '{'{OP_REMOVE, 32'h0000_0000, 8'h00},  1'b0, '0},
    '{'{OP_REMOVE, 32'hAAAA_AAAA, 8'hAA},  1'b0, '0},
    '{'{OP_REMOVE, 32'h5555_5555, 8'h55},  1'b0, '0},
    '{'{OP_REMOVE, 32'hFFFF_FFFF, 8'hFF},  1'b0, '0},
    '{'{OP_REMOVE, 32'h8000_0000, 8'h01},  1'b0, '0},
    '{'{OP_REMOVE, 32'h7FFF_FFFF, 8'h80},  1'b0, '0},
    '{'{OP_REMOVE, 32'h0F0F_0F0F, 8'h0F},  1'b0, '0},
    '{'{OP_REMOVE, 32'hF0F0_F0F0, 8'hF0},  1'b1, '{ST_EMPTY, 32'h0, 8'd0, 4'd0}},
    '{'{OP_INSERT, 32'h0000_0005, 8'd9},   1'b1, '{ST_OK, 32'h0, 8'd0, 4'd1}},
    '{'{OP_REMOVE, 32'h0000_0000, 8'd0},   1'b0, '0}
  };

  sorted_priority_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Applies one item to the predicted queue and returns the result it should give.
  function automatic out_item_t queue_step(input in_item_t it);
    out_item_t res;
    int        pos;
    res = '0;
    res.status = ST_OK;
    if (it.op == OP_INSERT) begin
      if (held_count >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
        full_refusals++;
      end else begin
        // Entries of lower priority move back; equal priorities keep arrival order.
        pos = held_count;
        while (pos > 0 && it.priority_in > held_prio[pos-1]) begin
          held_data[pos] = held_data[pos-1];
          held_prio[pos] = held_prio[pos-1];
          pos--;
        end
        held_data[pos] = it.data_in;
        held_prio[pos] = it.priority_in;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        res.status = ST_EMPTY;
        empty_refusals++;
      end else begin
        res.data_out     = held_data[0];
        res.priority_out = held_prio[0];
        for (int k = 1; k < held_count; k++) begin
          held_data[k-1] = held_data[k];
          held_prio[k-1] = held_prio[k];
        end
        held_count--;
      end
    end
    if (held_count > peak_fill) peak_fill = held_count;
    res.fill_count = 4'(held_count);
    return res;
  endfunction

  function automatic in_item_t random_item(input bit lean_insert);
    in_item_t it;
    it.op = ($urandom_range(99) < (lean_insert ? 70 : 30)) ? OP_INSERT : OP_REMOVE;
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(3))
          0: it.data_in = 32'h7FFF_FFFF;
          1: it.data_in = 32'h8000_0000;
          2: it.data_in = 32'h0000_0000;
          default: it.data_in = 32'hFFFF_FFFF;
        endcase
      end
      default: it.data_in = $urandom;
    endcase
    // Narrow priorities give many ties, which exercise arrival order.
    case ($urandom_range(3))
      0: it.priority_in = 8'($urandom_range(3));
      1: it.priority_in = $urandom_range(1) ? 8'd255 : 8'd0;
      default: it.priority_in = 8'($urandom_range(255));
    endcase
    return it;
  endfunction

  task automatic send_item(input in_item_t it, input bit typed, input out_item_t known);
    out_item_t predicted;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) begin
      input_stalls++;
      @(posedge clk);
    end
    predicted = queue_step(it);
    expected_results.push_back(typed ? known : predicted);
    items_sent++;
  endtask

  task automatic finish_phase();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input out_item_t want,
                                 input out_item_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("MISMATCH %s at cycle %0d: status %0d/%0d data %0h/%0h prio %0d/%0d fill %0d/%0d",
               what, cycle_count, want.status, got.status, want.data_out, got.data_out,
               want.priority_out, got.priority_out, want.fill_count, got.fill_count);
    end
  endtask

  // Result side: checks each accepted item and drives out_stall, including the long hold.
  initial begin : result_monitor
    out_item_t want;
    int        hold_left;
    bit        hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected", '0, out_item);
        end else begin
          want = expected_results.pop_front();
          if (out_item !== want) report_mismatch("field", want, out_item);
          results_checked++;
        end
      end
      if (hold_request && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int        send_pcts [4];
    int        stall_pcts [4];
    bit        lean_insert;
    send_pcts  = '{0, 85, 0, 37};
    stall_pcts = '{0, 0, 85, 37};
    lean_insert = 1'b1;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].result);
    end
    finish_phase();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_pcts[p];
      recv_stall_pct = stall_pcts[p];
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
        // Pick a filling or a draining run every 24 items so full and empty are both reached often.
        if (n % 24 == 0) lean_insert = 1'($urandom_range(1));
        send_item(random_item(lean_insert), 1'b0, '0);
      end
      finish_phase();
    end

    // The receiver holds off while items keep coming, so the block must stall its input.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b1;
    @(posedge clk);
    for (int n = 0; n < PRESSURE_ITEMS; n++) begin
      send_item(random_item(n < PRESSURE_ITEMS / 2), 1'b0, '0);
    end
    finish_phase();

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d items, %0d results checked, %0d full and %0d empty refusals.",
             items_sent, results_checked, full_refusals, empty_refusals);
    $display("Peak fill %0d of %0d, input stalled on %0d cycles, %0d mismatches.",
             peak_fill, QUEUE_DEPTH, input_stalls, mismatch_count);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/spq_out_buf.sv
rtl/sorted_priority_queue.sv
rtl/spq_checker.sv
verif/testbench.sv
